// File: rtl/bc5_pkg.sv
// ============================================================================
// bc5_pkg
// Shared types, constants and the palette weighting function of the BC5
// block decoder.
// ============================================================================
package bc5_pkg;

    localparam int BC5_MAX_SIDE_DEFAULT = 16384;

    localparam int BC5_CFG_INDEX_W = 4;
    localparam int BC5_CFG_DATA_W  = 15;
    localparam logic [BC5_CFG_INDEX_W-1:0] BC5_REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [BC5_CFG_INDEX_W-1:0] BC5_REG_IMAGE_HEIGHT = 4'd1;
    localparam logic [BC5_CFG_DATA_W-1:0]  BC5_SIDE_RESET       = 15'd16384;

    localparam int BC5_POS_W      = 12;
    localparam int BC5_OFFSET_W   = 29;
    localparam int BC5_CNT_W      = 4;
    localparam int BC5_INDEX_LSB  = 16;
    localparam int BC5_QUEUE_DEPTH = 2;
    localparam logic [BC5_CNT_W-1:0] BC5_TEXEL_LAST = 4'd15;

    // Weighted endpoint sums are at most 7 * 255 and fit in 11 bits. The
    // quotient by 7 or 5 is taken as a multiplication by a scaled reciprocal.
    localparam int BC5_SUM_W   = 11;
    localparam int BC5_RECIP_W = 12;
    localparam int BC5_RECIP_SHIFT = 14;
    localparam logic [BC5_RECIP_W-1:0] BC5_RECIP_7 = 12'd2341;
    localparam logic [BC5_RECIP_W-1:0] BC5_RECIP_5 = 12'd3277;
    localparam logic [BC5_SUM_W-1:0]   BC5_WHITE_SUM = 11'd1275;

    typedef struct packed {
        logic [63:0] red_block;
        logic [63:0] green_block;
    } bc5_block_t;

    typedef struct packed {
        logic [7:0]              red_value;
        logic [7:0]              green_value;
        logic [BC5_OFFSET_W-1:0] byte_offset;
        logic                    inside_image;
        logic                    last_texel;
        logic                    last_block;
    } bc5_texel_t;

    // One classified block as it waits between the front and the back end.
    typedef struct packed {
        logic [63:0]          red_block;
        logic [63:0]          green_block;
        logic                 red_mode7;
        logic                 green_mode7;
        logic [BC5_POS_W-1:0] block_column;
        logic [BC5_POS_W-1:0] block_row;
        logic                 last_block;
    } bc5_job_t;

    // Returns the weighted endpoint sum for one palette index. Indices 0 and
    // 1 carry the full divisor as weight so that the common division step
    // returns the endpoint itself; white in six-level mode is a fixed sum.
    function automatic logic [BC5_SUM_W-1:0] bc5_level_sum(
        input logic       mode7,
        input logic [7:0] e0,
        input logic [7:0] e1,
        input logic [2:0] idx
    );
        logic [2:0]           wa;
        logic [2:0]           wb;
        logic [2:0]           full;
        logic [BC5_SUM_W-1:0] sum;
        full = mode7 ? 3'd7 : 3'd5;
        wa   = 3'd0;
        wb   = 3'd0;
        priority if (idx == 3'd0)
        begin
            wa = full;
        end
        else if (idx == 3'd1)
        begin
            wb = full;
        end
        else if (mode7)
        begin
            wa = 3'(4'd8 - {1'b0, idx});
            wb = idx - 3'd1;
        end
        else if (idx <= 3'd5)
        begin
            wa = 3'd6 - idx;
            wb = idx - 3'd1;
        end
        else
        begin
            wa = 3'd0;
            wb = 3'd0;
        end
        if (!mode7 && (idx == 3'd7))
        begin
            sum = BC5_WHITE_SUM;
        end
        else
        begin
            sum = (BC5_SUM_W'(wa) * BC5_SUM_W'(e0)) + (BC5_SUM_W'(wb) * BC5_SUM_W'(e1));
        end
        return sum;
    endfunction

endpackage

// File: rtl/bc5_front.sv
// ============================================================================
// bc5_front
// Accepts blocks, holds the image size registers, tracks the block position
// and classifies the palette mode of each channel.
// ============================================================================
module bc5_front #(
    parameter  int MAX_SIDE = bc5_pkg::BC5_MAX_SIDE_DEFAULT,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   blk_valid,
    output logic                                   blk_ready,
    input  bc5_pkg::bc5_block_t                    blk_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bc5_pkg::BC5_CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bc5_pkg::BC5_CFG_DATA_W-1:0]     cfg_data,
    output logic                                   job_valid,
    input  logic                                   job_ready,
    output bc5_pkg::bc5_job_t                      job,
    output logic [SIDE_W-1:0]                      width,
    output logic [SIDE_W-1:0]                      height
);
    import bc5_pkg::*;

    localparam int CL_W = (BC5_CFG_DATA_W > SIDE_W) ? BC5_CFG_DATA_W : SIDE_W;
    localparam int NW   = ((BC5_POS_W + 1) > SIDE_W) ? (BC5_POS_W + 1) : SIDE_W;

    logic [BC5_CFG_DATA_W-1:0] image_width_reg;
    logic [BC5_CFG_DATA_W-1:0] image_height_reg;
    logic [BC5_POS_W-1:0]      column_reg;
    logic [BC5_POS_W-1:0]      column_next;
    logic [BC5_POS_W-1:0]      row_reg;
    logic [BC5_POS_W-1:0]      row_next;

    logic [SIDE_W:0]      wide_sum;
    logic [SIDE_W:0]      high_sum;
    logic [SIDE_W-2:0]    blocks_wide;
    logic [SIDE_W-2:0]    blocks_high;
    logic [BC5_POS_W:0]   next_col;
    logic [BC5_POS_W:0]   next_row;
    logic                 final_col;
    logic                 final_row;
    logic                 accept;

    function automatic logic [SIDE_W-1:0] side_clamp(input logic [BC5_CFG_DATA_W-1:0] v);
        logic [SIDE_W-1:0] r;
        priority if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (CL_W'(v) > CL_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= BC5_SIDE_RESET;
            image_height_reg <= BC5_SIDE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == BC5_REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data;
            end
            if (cfg_index == BC5_REG_IMAGE_HEIGHT)
            begin
                image_height_reg <= cfg_data;
            end
        end
    end

    assign width  = side_clamp(image_width_reg);
    assign height = side_clamp(image_height_reg);

    assign wide_sum    = {1'b0, width} + (SIDE_W + 1)'(3);
    assign high_sum    = {1'b0, height} + (SIDE_W + 1)'(3);
    assign blocks_wide = wide_sum[SIDE_W:2];
    assign blocks_high = high_sum[SIDE_W:2];

    assign next_col  = {1'b0, column_reg} + (BC5_POS_W + 1)'(1);
    assign next_row  = {1'b0, row_reg} + (BC5_POS_W + 1)'(1);
    assign final_col = NW'(next_col) >= NW'(blocks_wide);
    assign final_row = NW'(next_row) >= NW'(blocks_high);

    assign job_valid = blk_valid;
    assign blk_ready = job_ready;
    assign accept    = blk_valid && job_ready;

    always_comb
    begin
        job.red_block    = blk_data.red_block;
        job.green_block  = blk_data.green_block;
        job.red_mode7    = blk_data.red_block[7:0] > blk_data.red_block[15:8];
        job.green_mode7  = blk_data.green_block[7:0] > blk_data.green_block[15:8];
        job.block_column = column_reg;
        job.block_row    = row_reg;
        job.last_block   = final_col && final_row;
    end

    // Raster block order, with both coordinates wrapping back to zero.
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (final_col)
            begin
                column_next = '0;
                row_next    = final_row ? '0 : next_row[BC5_POS_W-1:0];
            end
            else
            begin
                column_next = next_col[BC5_POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: rtl/bc5_queue.sv
// ============================================================================
// bc5_queue
// Short first-in first-out queue of classified blocks between the front and
// the back end.
// ============================================================================
module bc5_queue #(
    parameter int DEPTH = bc5_pkg::BC5_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  bc5_pkg::bc5_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output bc5_pkg::bc5_job_t pop_data
);
    import bc5_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bc5_job_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/bc5_back.sv
// ============================================================================
// bc5_back
// Walks the sixteen texels of each block through a two-stage pipeline:
// palette sum and row product, then division, offset and output register.
// ============================================================================
module bc5_back #(
    parameter  int MAX_SIDE = bc5_pkg::BC5_MAX_SIDE_DEFAULT,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  bc5_pkg::bc5_job_t    job,
    input  logic [SIDE_W-1:0]    width,
    input  logic [SIDE_W-1:0]    height,
    output logic                 texel_valid,
    input  logic                 texel_ready,
    output bc5_pkg::bc5_texel_t  texel_data
);
    import bc5_pkg::*;

    localparam int COORD_W = BC5_POS_W + 2;
    localparam int MUL_W   = COORD_W + SIDE_W + 1;
    localparam int PROD_W  = (MUL_W > BC5_OFFSET_W) ? MUL_W : BC5_OFFSET_W;
    localparam int CMP_W   = (COORD_W > SIDE_W) ? COORD_W : SIDE_W;
    localparam int QPROD_W = BC5_SUM_W + BC5_RECIP_W;

    // Current block and texel sequencer
    bc5_job_t              cur_reg;
    logic                  cur_valid_reg;
    logic [BC5_CNT_W-1:0]  texel_cnt_reg;

    // First stage
    logic                  s1_valid_reg;
    logic [BC5_SUM_W-1:0]  s1_red_sum_reg;
    logic                  s1_red_div7_reg;
    logic [BC5_SUM_W-1:0]  s1_green_sum_reg;
    logic                  s1_green_div7_reg;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic [COORD_W-1:0]    s1_col_reg;
    logic                  s1_inside_reg;
    logic                  s1_last_texel_reg;
    logic                  s1_last_block_reg;

    // Output register
    logic                  out_valid_reg;
    bc5_texel_t            out_reg;

    logic                  out_adv;
    logic                  s1_free;
    logic                  issue;
    logic                  load;
    logic [5:0]            idx_lsb;
    logic [2:0]            red_idx;
    logic [2:0]            green_idx;
    logic [COORD_W-1:0]    tex_row;
    logic [COORD_W-1:0]    tex_col;
    logic [BC5_RECIP_W-1:0] red_recip;
    logic [BC5_RECIP_W-1:0] green_recip;
    logic [QPROD_W-1:0]    red_q;
    logic [QPROD_W-1:0]    green_q;
    logic [PROD_W-1:0]     offset_sum;
    bc5_texel_t            out_next;

    assign out_adv   = !out_valid_reg || texel_ready;
    assign s1_free   = !s1_valid_reg || out_adv;
    assign issue     = cur_valid_reg && s1_free;
    assign load      = !cur_valid_reg || (issue && (texel_cnt_reg == BC5_TEXEL_LAST));
    assign job_ready = load;

    assign idx_lsb   = 6'(BC5_INDEX_LSB + 3 * int'(texel_cnt_reg));
    assign red_idx   = cur_reg.red_block[idx_lsb +: 3];
    assign green_idx = cur_reg.green_block[idx_lsb +: 3];
    assign tex_row   = {cur_reg.block_row, texel_cnt_reg[3:2]};
    assign tex_col   = {cur_reg.block_column, texel_cnt_reg[1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            texel_cnt_reg <= '0;
        end
        else if (load)
        begin
            cur_valid_reg <= job_valid;
            texel_cnt_reg <= '0;
        end
        else if (issue)
        begin
            texel_cnt_reg <= texel_cnt_reg + BC5_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            cur_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_red_sum_reg    <= bc5_level_sum(cur_reg.red_mode7, cur_reg.red_block[7:0],
                                               cur_reg.red_block[15:8], red_idx);
            s1_green_sum_reg  <= bc5_level_sum(cur_reg.green_mode7, cur_reg.green_block[7:0],
                                               cur_reg.green_block[15:8], green_idx);
            s1_red_div7_reg   <= cur_reg.red_mode7;
            s1_green_div7_reg <= cur_reg.green_mode7;
            s1_prod_reg       <= PROD_W'(tex_row) * PROD_W'(width);
            s1_col_reg        <= tex_col;
            s1_inside_reg     <= (CMP_W'(tex_col) < CMP_W'(width)) &&
                                 (CMP_W'(tex_row) < CMP_W'(height));
            s1_last_texel_reg <= texel_cnt_reg == BC5_TEXEL_LAST;
            s1_last_block_reg <= cur_reg.last_block;
        end
    end

    // The reciprocal products are exact floors for sums up to 7 * 255.
    assign red_recip   = s1_red_div7_reg ? BC5_RECIP_7 : BC5_RECIP_5;
    assign green_recip = s1_green_div7_reg ? BC5_RECIP_7 : BC5_RECIP_5;
    assign red_q       = QPROD_W'(s1_red_sum_reg) * QPROD_W'(red_recip);
    assign green_q     = QPROD_W'(s1_green_sum_reg) * QPROD_W'(green_recip);
    assign offset_sum  = s1_prod_reg + PROD_W'(s1_col_reg);

    always_comb
    begin
        out_next.red_value    = red_q[BC5_RECIP_SHIFT +: 8];
        out_next.green_value  = green_q[BC5_RECIP_SHIFT +: 8];
        out_next.byte_offset  = {offset_sum[BC5_OFFSET_W-2:0], 1'b0};
        out_next.inside_image = s1_inside_reg;
        out_next.last_texel   = s1_last_texel_reg;
        out_next.last_block   = s1_last_block_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign texel_valid = out_valid_reg;
    assign texel_data  = out_reg;

endmodule

// File: rtl/bc5_block_decoder.sv
// ============================================================================
// bc5_block_decoder
// BC5 block decoder: one 16-byte block in, sixteen red/green texels out.
//
// Each accepted block yields sixteen texels in row-major order within the
// block, one per clock cycle while the receiver accepts them; the texel
// sequencer in the back end issues them to the single texel output. The
// first texel of a block passes through the queue entry, the current block
// register, the first stage and the output register. A two-entry queue lets
// further blocks be accepted while texels are still being delivered or held
// by a stalled receiver. Block positions advance in raster block order from
// the top-left corner after reset; image_width (index 0) and image_height
// (index 1) are clamped to 1..MAX_SIDE and should only be written while the
// decoder is idle. Texels beyond the image edge are still delivered with
// inside_image low.
// ============================================================================
module bc5_block_decoder #(
    parameter  int MAX_SIDE = bc5_pkg::BC5_MAX_SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                blk_valid,
    output logic                                blk_ready,
    input  bc5_pkg::bc5_block_t                 blk_data,
    output logic                                texel_valid,
    input  logic                                texel_ready,
    output bc5_pkg::bc5_texel_t                 texel_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bc5_pkg::BC5_CFG_INDEX_W-1:0] cfg_index,
    input  logic [bc5_pkg::BC5_CFG_DATA_W-1:0]  cfg_data
);
    import bc5_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);

    logic              front_valid;
    logic              front_ready;
    bc5_job_t          front_job;
    logic              queue_valid;
    logic              queue_ready;
    bc5_job_t          queue_job;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;

    bc5_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job),
        .width     (width),
        .height    (height)
    );

    bc5_queue #(
        .DEPTH (BC5_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_job)
    );

    bc5_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (queue_valid),
        .job_ready   (queue_ready),
        .job         (queue_job),
        .width       (width),
        .height      (height),
        .texel_valid (texel_valid),
        .texel_ready (texel_ready),
        .texel_data  (texel_data)
    );

endmodule

// File: rtl/bc5_checker.sv
// ============================================================================
// bc5_checker
// Port-level checks on the BC5 block decoder: texel framing, block
// consistency and the number of blocks in flight.
// ============================================================================
module bc5_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                blk_valid,
    input logic                blk_ready,
    input logic                texel_valid,
    input logic                texel_ready,
    input bc5_pkg::bc5_texel_t texel_data
);
    import bc5_pkg::*;

    localparam int PEND_W = $clog2(BC5_QUEUE_DEPTH + 4);

    logic                 blk_accept;
    logic                 texel_accept;
    logic [BC5_CNT_W-1:0] texel_cnt_reg;
    logic [PEND_W-1:0]    pending_reg;
    logic                 mid_block_reg;
    logic                 prev_last_block_reg;

    assign blk_accept   = blk_valid && blk_ready;
    assign texel_accept = texel_valid && texel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_cnt_reg       <= '0;
            pending_reg         <= '0;
            mid_block_reg       <= 1'b0;
            prev_last_block_reg <= 1'b0;
        end
        else
        begin
            if (texel_accept)
            begin
                texel_cnt_reg       <= texel_cnt_reg + BC5_CNT_W'(1);
                mid_block_reg       <= !texel_data.last_texel;
                prev_last_block_reg <= texel_data.last_block;
            end
            pending_reg <= pending_reg + PEND_W'(blk_accept)
                           - PEND_W'(texel_accept && texel_data.last_texel);
        end
    end

    // Every sixteenth delivered texel closes a block, and no other does.
    a_last_texel_framing: assert property (@(posedge clk) disable iff (!rst_n)
        texel_accept |-> (texel_data.last_texel == (texel_cnt_reg == BC5_TEXEL_LAST)))
        else $error("last_texel out of step with the texel count");

    // All texels of one block agree on whether it is the final block.
    a_last_block_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (texel_accept && mid_block_reg) |-> (texel_data.last_block == prev_last_block_reg))
        else $error("last_block changed within a block");

    // Blocks in flight never exceed the queue plus the block in the
    // sequencer and one whose tail is still in the pipeline.
    a_blocks_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(BC5_QUEUE_DEPTH + 2))
        else $error("more blocks in flight than the decoder can hold");

    a_texel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (texel_valid && !texel_ready) |=> (texel_valid && $stable(texel_data)))
        else $error("texel transaction dropped or changed while stalled");

endmodule

bind bc5_block_decoder bc5_checker u_bc5_checker (.*);
